// ===== design/lav_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, types and state encodings for the look-at view matrix unit.
// Depends on nothing; every other design file imports it.
package lav_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DATA_W    = 32;
    localparam int DIR_W     = DATA_W + 1;
    localparam int UNIT_W    = FRAC_BITS + 2;
    localparam int TUP_W     = FRAC_BITS + 4;
    localparam int CR_W      = UNIT_W + DATA_W + 1;
    localparam int PROD_W    = TUP_W + DATA_W;
    localparam int ACC_W     = TUP_W + DATA_W + 2;
    localparam int ACC_N     = 9;
    localparam int ACC_IDX_W = $clog2(ACC_N);
    localparam int MAG_W     = CR_W;
    localparam int NRM_HI    = 30;
    localparam int COARSE    = 8;
    localparam int SQ_W      = 64;
    localparam int SQRT_STEPS = 32;
    localparam int LEN_W     = 32;
    localparam int QUO_W     = FRAC_BITS + 1;
    localparam int DIV_W     = LEN_W + FRAC_BITS;
    localparam int STEP_W    = 5;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W    = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W    = $clog2(QUEUE_DEPTH + 1);
    localparam logic [DATA_W-1:0] ONE_Q = DATA_W'(1) << FRAC_BITS;

    typedef struct packed {
        logic [2:0][DATA_W-1:0] eye;
        logic [2:0][DIR_W-1:0]  dir;
        logic [2:0][DATA_W-1:0] up;
    } lav_item_t;

    typedef struct packed {
        logic done;
        logic ok;
    } lav_nstat_t;

    typedef struct packed {
        logic                 valid;
        logic [ACC_IDX_W-1:0] dst;
        logic                 sub;
        logic                 first;
    } lav_mctl_t;

    typedef enum logic [2:0] {
        N_IDLE,
        N_MAX,
        N_SCALE,
        N_SQ,
        N_SQRT,
        N_DIV
    } lav_nstate_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_FSTART,
        B_FWAIT,
        B_CROSS,
        B_SSTART,
        B_SWAIT,
        B_DOTS,
        B_FINISH
    } lav_bstate_t;

endpackage

// ===== design/lav_front.sv =====
`timescale 1ns / 1ps
// Front end: takes a camera request, forms the view direction and pushes it.
// Depends on lav_pkg.
module lav_front (
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic signed [lav_pkg::DATA_W-1:0] eye_x,
    input  logic signed [lav_pkg::DATA_W-1:0] eye_y,
    input  logic signed [lav_pkg::DATA_W-1:0] eye_z,
    input  logic signed [lav_pkg::DATA_W-1:0] target_x,
    input  logic signed [lav_pkg::DATA_W-1:0] target_y,
    input  logic signed [lav_pkg::DATA_W-1:0] target_z,
    input  logic signed [lav_pkg::DATA_W-1:0] up_x,
    input  logic signed [lav_pkg::DATA_W-1:0] up_y,
    input  logic signed [lav_pkg::DATA_W-1:0] up_z,
    output logic                             push_valid,
    input  logic                             push_ready,
    output lav_pkg::lav_item_t               push_item
);
    import lav_pkg::*;

    logic signed [DIR_W-1:0] dir_x, dir_y, dir_z;

    assign dir_x = DIR_W'(target_x) - DIR_W'(eye_x);
    assign dir_y = DIR_W'(target_y) - DIR_W'(eye_y);
    assign dir_z = DIR_W'(target_z) - DIR_W'(eye_z);

    assign push_valid = in_valid;
    assign in_ready   = push_ready;

    always_comb
    begin
        push_item.eye = {eye_z, eye_y, eye_x};
        push_item.dir = {dir_z, dir_y, dir_x};
        push_item.up  = {up_z, up_y, up_x};
    end

endmodule

// ===== design/lav_queue.sv =====
`timescale 1ns / 1ps
// Short request queue between the front end and the back end.
// Depends on lav_pkg.
module lav_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push_valid,
    output logic               push_ready,
    input  lav_pkg::lav_item_t push_item,
    output logic               pop_valid,
    input  logic               pop_ready,
    output lav_pkg::lav_item_t pop_item
);
    import lav_pkg::*;

    lav_item_t          mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0]  cnt_reg;
    logic               do_push, do_pop;

    assign push_ready = cnt_reg != QCNT_W'(QUEUE_DEPTH);
    assign pop_valid  = cnt_reg != '0;
    assign pop_item   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                       : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                       : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

// ===== design/lav_norm.sv =====
`timescale 1ns / 1ps
// Iterative vector normalizer: block scale, sum of squares, bit-serial square
// root and restoring divide per component. Depends on lav_pkg.
module lav_norm (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic signed [lav_pkg::CR_W-1:0]   vec [3],
    output lav_pkg::lav_nstat_t               stat,
    output logic signed [lav_pkg::UNIT_W-1:0] unit [3]
);
    import lav_pkg::*;

    localparam logic [MAG_W-1:0] M_TOP   = MAG_W'(1) << NRM_HI;
    localparam logic [MAG_W-1:0] M_BOT   = MAG_W'(1) << (NRM_HI - 1);
    localparam logic [MAG_W-1:0] M_TOP_C = MAG_W'(1) << (NRM_HI + COARSE);
    localparam logic [MAG_W-1:0] M_BOT_C = MAG_W'(1) << (NRM_HI - 1 - COARSE);
    localparam logic [SQ_W-1:0]  BIT_INIT = SQ_W'(1) << (SQ_W - 2);
    localparam int SQC_W = $clog2(SQRT_STEPS);
    localparam int QC_W  = $clog2(QUO_W);

    lav_nstate_t state_reg, state_next;
    logic [MAG_W-1:0]          mag_reg [3];
    logic                      neg_reg [3];
    logic [MAG_W-1:0]          m_reg;
    logic [1:0]                k_reg;
    logic [2*NRM_HI-1:0]       sq_reg;
    logic [SQ_W-1:0]           x_reg, res_reg, bit_reg;
    logic [SQC_W-1:0]          cnt_reg;
    logic [LEN_W-1:0]          len_reg;
    logic [DIV_W-1:0]          rem_reg, dvs_reg;
    logic [QUO_W-1:0]          q_reg;
    logic [QC_W-1:0]           j_reg;
    logic signed [UNIT_W-1:0]  unit_reg [3];
    logic                      done_reg, done_next;
    logic                      ok_reg, ok_next;

    logic [MAG_W-1:0]  mag_max;
    logic [1:0]        rd_idx;
    logic [MAG_W-1:0]  rd_mag;
    logic [NRM_HI-1:0] rd_scl;
    logic [SQ_W-1:0]   trial, res_step, x_step;
    logic              ge_sq, ge_div;
    logic [QUO_W-1:0]  q_step;
    logic              scale_ok, sqrt_last, div_last;
    logic signed [UNIT_W-1:0] q_signed;

    always_comb
    begin
        mag_max = mag_reg[0];
        if (mag_reg[1] > mag_max)
        begin
            mag_max = mag_reg[1];
        end
        if (mag_reg[2] > mag_max)
        begin
            mag_max = mag_reg[2];
        end
    end

    // divide phase preloads the next component
    assign rd_idx = (state_reg == N_DIV) ? k_reg + 2'd1 : k_reg;

    always_comb
    begin
        unique case (rd_idx)
            2'd0:    rd_mag = mag_reg[0];
            2'd1:    rd_mag = mag_reg[1];
            2'd2:    rd_mag = mag_reg[2];
            default: rd_mag = mag_reg[0];
        endcase
    end

    assign rd_scl    = rd_mag[NRM_HI-1:0];
    assign trial     = res_reg + bit_reg;
    assign ge_sq     = x_reg >= trial;
    assign res_step  = ge_sq ? (res_reg >> 1) + bit_reg : res_reg >> 1;
    assign x_step    = ge_sq ? x_reg - trial : x_reg;
    assign ge_div    = rem_reg >= dvs_reg;
    assign q_step    = {q_reg[QUO_W-2:0], ge_div};
    assign q_signed  = $signed(UNIT_W'(q_step));
    assign scale_ok  = (m_reg < M_TOP) && (m_reg >= M_BOT);
    assign sqrt_last = cnt_reg == SQC_W'(SQRT_STEPS - 1);
    assign div_last  = (j_reg == '0) && (k_reg == 2'd2);

    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        ok_next    = ok_reg;
        unique case (state_reg)
            N_IDLE:
            begin
                if (start)
                begin
                    state_next = N_MAX;
                end
            end
            N_MAX:
            begin
                if (mag_max == '0)
                begin
                    state_next = N_IDLE;
                    done_next  = 1'b1;
                    ok_next    = 1'b0;
                end
                else
                begin
                    state_next = N_SCALE;
                end
            end
            N_SCALE:
            begin
                if (scale_ok)
                begin
                    state_next = N_SQ;
                end
            end
            N_SQ:
            begin
                if (k_reg == 2'd3)
                begin
                    state_next = N_SQRT;
                end
            end
            N_SQRT:
            begin
                if (sqrt_last)
                begin
                    state_next = N_DIV;
                end
            end
            N_DIV:
            begin
                if (div_last)
                begin
                    state_next = N_IDLE;
                    done_next  = 1'b1;
                    ok_next    = 1'b1;
                end
            end
            default:
            begin
                state_next = N_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= N_IDLE;
            done_reg  <= 1'b0;
            ok_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            ok_reg    <= ok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            N_IDLE:
            begin
                if (start)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        neg_reg[i] <= vec[i][CR_W-1];
                        mag_reg[i] <= vec[i][CR_W-1] ? $unsigned(-vec[i]) : $unsigned(vec[i]);
                    end
                end
            end
            N_MAX:
            begin
                m_reg <= mag_max;
                if (mag_max == '0)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        unit_reg[i] <= '0;
                    end
                end
            end
            N_SCALE:
            begin
                // same shift on every component; right shifts drop bits
                priority if (m_reg >= M_TOP_C)
                begin
                    m_reg <= m_reg >> COARSE;
                    for (int i = 0; i < 3; i++) mag_reg[i] <= mag_reg[i] >> COARSE;
                end
                else if (m_reg >= M_TOP)
                begin
                    m_reg <= m_reg >> 1;
                    for (int i = 0; i < 3; i++) mag_reg[i] <= mag_reg[i] >> 1;
                end
                else if (m_reg < M_BOT_C)
                begin
                    m_reg <= m_reg << COARSE;
                    for (int i = 0; i < 3; i++) mag_reg[i] <= mag_reg[i] << COARSE;
                end
                else if (m_reg < M_BOT)
                begin
                    m_reg <= m_reg << 1;
                    for (int i = 0; i < 3; i++) mag_reg[i] <= mag_reg[i] << 1;
                end
                else
                begin
                    k_reg <= 2'd0;
                    x_reg <= '0;
                end
            end
            N_SQ:
            begin
                if (k_reg != 2'd3)
                begin
                    sq_reg <= rd_scl * rd_scl;
                end
                if (k_reg != 2'd0)
                begin
                    x_reg <= x_reg + SQ_W'(sq_reg);
                end
                k_reg   <= (k_reg == 2'd3) ? 2'd0 : k_reg + 2'd1;
                res_reg <= '0;
                bit_reg <= BIT_INIT;
                cnt_reg <= '0;
            end
            N_SQRT:
            begin
                x_reg   <= x_step;
                res_reg <= res_step;
                bit_reg <= bit_reg >> 2;
                cnt_reg <= cnt_reg + 1'b1;
                if (sqrt_last)
                begin
                    len_reg <= res_step[LEN_W-1:0];
                    rem_reg <= DIV_W'(mag_reg[0][NRM_HI-1:0]) << FRAC_BITS;
                    dvs_reg <= DIV_W'(res_step[LEN_W-1:0]) << FRAC_BITS;
                    q_reg   <= '0;
                    j_reg   <= QC_W'(QUO_W - 1);
                    k_reg   <= 2'd0;
                end
            end
            N_DIV:
            begin
                rem_reg <= ge_div ? rem_reg - dvs_reg : rem_reg;
                dvs_reg <= dvs_reg >> 1;
                q_reg   <= q_step;
                j_reg   <= j_reg - 1'b1;
                if (j_reg == '0)
                begin
                    unit_reg[k_reg] <= neg_reg[k_reg] ? -q_signed : q_signed;
                    k_reg   <= k_reg + 2'd1;
                    rem_reg <= DIV_W'(rd_scl) << FRAC_BITS;
                    dvs_reg <= DIV_W'(len_reg) << FRAC_BITS;
                    q_reg   <= '0;
                    j_reg   <= QC_W'(QUO_W - 1);
                end
            end
            default:
            begin
            end
        endcase
    end

    assign stat.done = done_reg;
    assign stat.ok   = ok_reg;
    assign unit      = unit_reg;

endmodule

// ===== design/lav_back.sv =====
`timescale 1ns / 1ps
// Back end: sequences the normalizer and a shared multiply-accumulate, then
// drains the four matrix rows from a result bank. Depends on lav_pkg.
module lav_back (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              q_valid,
    output logic                              q_ready,
    input  lav_pkg::lav_item_t                q_item,
    output logic                              nrm_start,
    output logic signed [lav_pkg::CR_W-1:0]   nrm_vec [3],
    input  lav_pkg::lav_nstat_t               nrm_stat,
    input  logic signed [lav_pkg::UNIT_W-1:0] nrm_unit [3],
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [1:0]                        row_index,
    output logic signed [lav_pkg::DATA_W-1:0] col0,
    output logic signed [lav_pkg::DATA_W-1:0] col1,
    output logic signed [lav_pkg::DATA_W-1:0] col2,
    output logic signed [lav_pkg::DATA_W-1:0] col3,
    output logic                              degenerate,
    output logic                              last_row
);
    import lav_pkg::*;

    localparam logic [STEP_W-1:0] STEP_X_END   = STEP_W'(6);
    localparam logic [STEP_W-1:0] STEP_Y_BEGIN = STEP_W'(8);
    localparam logic [STEP_W-1:0] STEP_Y_END   = STEP_W'(23);
    localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) << (FRAC_BITS - 1);

    function automatic logic signed [DATA_W-1:0] sat_data(input logic signed [ACC_W:0] v);
        logic [ACC_W-DATA_W+1:0] hi;
        hi = v[ACC_W:DATA_W-1];
        if ((&hi) || !(|hi))
        begin
            return v[DATA_W-1:0];
        end
        return v[ACC_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
    endfunction

    lav_bstate_t state_reg, state_next;
    logic signed [DATA_W-1:0] eye_reg [3];
    logic signed [DIR_W-1:0]  dir_reg [3];
    logic signed [DATA_W-1:0] up_reg [3];
    logic signed [UNIT_W-1:0] f_reg [3];
    logic signed [UNIT_W-1:0] s_reg [3];
    logic                     okf_reg, oks_reg;
    logic signed [ACC_W-1:0]  acc_reg [ACC_N];
    logic [STEP_W-1:0]        step_reg;
    logic signed [PROD_W-1:0] prod_reg;
    lav_mctl_t                pctl_reg, mctl;

    logic signed [UNIT_W-1:0] bank_s_reg [3];
    logic signed [TUP_W-1:0]  bank_u_reg [3];
    logic signed [UNIT_W-1:0] bank_f_reg [3];
    logic signed [DATA_W-1:0] bank_t_reg [3];
    logic                     bank_deg_reg;
    logic                     bank_valid_reg;
    logic [1:0]               row_reg;

    logic signed [TUP_W-1:0]  a_op;
    logic signed [DATA_W-1:0] b_op;
    logic signed [TUP_W-1:0]  u_val [3];
    logic signed [DATA_W-1:0] t_val [3];
    logic signed [ACC_W-1:0]  acc_base, acc_new, prod_ext;
    logic                     out_take, bank_free, bank_load, pop;

    assign out_take  = bank_valid_reg && out_ready;
    assign bank_free = !bank_valid_reg || (out_ready && row_reg == 2'd3);
    assign bank_load = (state_reg == B_FINISH) && bank_free;
    assign pop       = q_valid && q_ready;

    always_comb
    begin
        state_next = state_reg;
        q_ready    = 1'b0;
        nrm_start  = 1'b0;
        unique case (state_reg)
            B_IDLE:
            begin
                q_ready = 1'b1;
                if (q_valid)
                begin
                    state_next = B_FSTART;
                end
            end
            B_FSTART:
            begin
                nrm_start  = 1'b1;
                state_next = B_FWAIT;
            end
            B_FWAIT:
            begin
                if (nrm_stat.done)
                begin
                    state_next = B_CROSS;
                end
            end
            B_CROSS:
            begin
                if (step_reg == STEP_X_END)
                begin
                    state_next = B_SSTART;
                end
            end
            B_SSTART:
            begin
                nrm_start  = 1'b1;
                state_next = B_SWAIT;
            end
            B_SWAIT:
            begin
                if (nrm_stat.done)
                begin
                    state_next = B_DOTS;
                end
            end
            B_DOTS:
            begin
                if (step_reg == STEP_Y_END)
                begin
                    state_next = B_FINISH;
                end
            end
            B_FINISH:
            begin
                if (bank_free)
                begin
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= B_IDLE;
            pctl_reg       <= '0;
            bank_valid_reg <= 1'b0;
            row_reg        <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            pctl_reg  <= mctl;
            if (bank_load)
            begin
                bank_valid_reg <= 1'b1;
                row_reg        <= 2'd0;
            end
            else if (out_take)
            begin
                row_reg <= row_reg + 2'd1;
                if (row_reg == 2'd3)
                begin
                    bank_valid_reg <= 1'b0;
                end
            end
        end
    end

    // rounded true-up from the cross-product accumulators, saturated translation from the dot products
    always_comb
    begin
        logic signed [ACC_W-1:0] sh;
        logic signed [ACC_W:0]   tv;
        for (int i = 0; i < 3; i++)
        begin
            sh       = (acc_reg[3 + i] + HALF) >>> FRAC_BITS;
            u_val[i] = $signed(sh[TUP_W-1:0]);
        end
        for (int i = 0; i < 3; i++)
        begin
            sh = (acc_reg[6 + i] + HALF) >>> FRAC_BITS;
            tv = (ACC_W + 1)'(sh);
            if (i != 2)
            begin
                tv = -tv;
            end
            t_val[i] = sat_data(tv);
        end
    end

    // multiply schedule: cross(f, up), cross(s, f), then the eye dot products
    always_comb
    begin
        a_op = '0;
        b_op = '0;
        mctl = '0;
        if (state_reg == B_CROSS || state_reg == B_DOTS)
        begin
            mctl.valid = 1'b1;
            unique case (step_reg)
                5'd0:
                begin
                    a_op = TUP_W'(f_reg[1]); b_op = up_reg[2];
                    mctl.dst = 4'd0; mctl.first = 1'b1;
                end
                5'd1:
                begin
                    a_op = TUP_W'(f_reg[2]); b_op = up_reg[1];
                    mctl.dst = 4'd0; mctl.sub = 1'b1;
                end
                5'd2:
                begin
                    a_op = TUP_W'(f_reg[2]); b_op = up_reg[0];
                    mctl.dst = 4'd1; mctl.first = 1'b1;
                end
                5'd3:
                begin
                    a_op = TUP_W'(f_reg[0]); b_op = up_reg[2];
                    mctl.dst = 4'd1; mctl.sub = 1'b1;
                end
                5'd4:
                begin
                    a_op = TUP_W'(f_reg[0]); b_op = up_reg[1];
                    mctl.dst = 4'd2; mctl.first = 1'b1;
                end
                5'd5:
                begin
                    a_op = TUP_W'(f_reg[1]); b_op = up_reg[0];
                    mctl.dst = 4'd2; mctl.sub = 1'b1;
                end
                5'd8:
                begin
                    a_op = TUP_W'(s_reg[1]); b_op = DATA_W'(f_reg[2]);
                    mctl.dst = 4'd3; mctl.first = 1'b1;
                end
                5'd9:
                begin
                    a_op = TUP_W'(s_reg[2]); b_op = DATA_W'(f_reg[1]);
                    mctl.dst = 4'd3; mctl.sub = 1'b1;
                end
                5'd10:
                begin
                    a_op = TUP_W'(s_reg[2]); b_op = DATA_W'(f_reg[0]);
                    mctl.dst = 4'd4; mctl.first = 1'b1;
                end
                5'd11:
                begin
                    a_op = TUP_W'(s_reg[0]); b_op = DATA_W'(f_reg[2]);
                    mctl.dst = 4'd4; mctl.sub = 1'b1;
                end
                5'd12:
                begin
                    a_op = TUP_W'(s_reg[0]); b_op = DATA_W'(f_reg[1]);
                    mctl.dst = 4'd5; mctl.first = 1'b1;
                end
                5'd13:
                begin
                    a_op = TUP_W'(s_reg[1]); b_op = DATA_W'(f_reg[0]);
                    mctl.dst = 4'd5; mctl.sub = 1'b1;
                end
                5'd14:
                begin
                    a_op = TUP_W'(s_reg[0]); b_op = eye_reg[0];
                    mctl.dst = 4'd6; mctl.first = 1'b1;
                end
                5'd15:
                begin
                    a_op = TUP_W'(s_reg[1]); b_op = eye_reg[1];
                    mctl.dst = 4'd6;
                end
                5'd16:
                begin
                    a_op = TUP_W'(s_reg[2]); b_op = eye_reg[2];
                    mctl.dst = 4'd6;
                end
                5'd17:
                begin
                    a_op = TUP_W'(f_reg[0]); b_op = eye_reg[0];
                    mctl.dst = 4'd8; mctl.first = 1'b1;
                end
                5'd18:
                begin
                    a_op = TUP_W'(f_reg[1]); b_op = eye_reg[1];
                    mctl.dst = 4'd8;
                end
                5'd19:
                begin
                    a_op = TUP_W'(f_reg[2]); b_op = eye_reg[2];
                    mctl.dst = 4'd8;
                end
                5'd20:
                begin
                    a_op = u_val[0]; b_op = eye_reg[0];
                    mctl.dst = 4'd7; mctl.first = 1'b1;
                end
                5'd21:
                begin
                    a_op = u_val[1]; b_op = eye_reg[1];
                    mctl.dst = 4'd7;
                end
                5'd22:
                begin
                    a_op = u_val[2]; b_op = eye_reg[2];
                    mctl.dst = 4'd7;
                end
                default: mctl.valid = 1'b0;
            endcase
        end
    end

    assign prod_ext = ACC_W'(prod_reg);
    assign acc_base = pctl_reg.first ? '0 : acc_reg[pctl_reg.dst];
    assign acc_new  = pctl_reg.sub ? acc_base - prod_ext : acc_base + prod_ext;

    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_W'(a_op) * PROD_W'(b_op);
        if (pctl_reg.valid)
        begin
            acc_reg[pctl_reg.dst] <= acc_new;
        end
        if (pop)
        begin
            for (int i = 0; i < 3; i++)
            begin
                eye_reg[i] <= $signed(q_item.eye[i]);
                dir_reg[i] <= $signed(q_item.dir[i]);
                up_reg[i]  <= $signed(q_item.up[i]);
            end
        end
        unique case (state_reg)
            B_FWAIT:
            begin
                step_reg <= '0;
                if (nrm_stat.done)
                begin
                    f_reg   <= nrm_unit;
                    okf_reg <= nrm_stat.ok;
                end
            end
            B_SWAIT:
            begin
                step_reg <= STEP_Y_BEGIN;
                if (nrm_stat.done)
                begin
                    s_reg   <= nrm_unit;
                    oks_reg <= nrm_stat.ok;
                end
            end
            B_CROSS, B_DOTS:
            begin
                step_reg <= step_reg + 1'b1;
            end
            default:
            begin
            end
        endcase
        if (bank_load)
        begin
            bank_s_reg   <= s_reg;
            bank_u_reg   <= u_val;
            bank_f_reg   <= f_reg;
            bank_t_reg   <= t_val;
            bank_deg_reg <= !(okf_reg && oks_reg);
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            nrm_vec[i] = (state_reg == B_FSTART) ? CR_W'(dir_reg[i]) : acc_reg[i][CR_W-1:0];
        end
    end

    always_comb
    begin
        col3 = '0;
        unique case (row_reg)
            2'd0:
            begin
                col0 = DATA_W'(bank_s_reg[0]);
                col1 = DATA_W'(bank_u_reg[0]);
                col2 = DATA_W'(-bank_f_reg[0]);
            end
            2'd1:
            begin
                col0 = DATA_W'(bank_s_reg[1]);
                col1 = DATA_W'(bank_u_reg[1]);
                col2 = DATA_W'(-bank_f_reg[1]);
            end
            2'd2:
            begin
                col0 = DATA_W'(bank_s_reg[2]);
                col1 = DATA_W'(bank_u_reg[2]);
                col2 = DATA_W'(-bank_f_reg[2]);
            end
            default:
            begin
                col0 = bank_t_reg[0];
                col1 = bank_t_reg[1];
                col2 = bank_t_reg[2];
                col3 = ONE_Q;
            end
        endcase
    end

    assign out_valid  = bank_valid_reg;
    assign row_index  = row_reg;
    assign degenerate = bank_deg_reg;
    assign last_row   = row_reg == 2'd3;

endmodule

// ===== design/look_at_view_matrix_unit.sv =====
`timescale 1ns / 1ps
// Top level of the look-at view matrix unit: front end, request queue,
// normalizer and back end. Depends on lav_pkg and all lav_* modules.
//
//   port group   dir  handshake            payload
//   request      in   in_valid/in_ready    eye_*, target_*, up_* (Q16.16)
//   row result   out  out_valid/out_ready  row_index, col0..col3, degenerate, last_row
//
// Each request passes twice through the shared normalizer in the back end
// (up to eight scaling shifts, 32-step square root, three 17-step divides);
// a zero-length vector ends its pass early. Four row results follow per
// request, one per cycle while out_ready is high. The queue holds two requests
// and the result bank lets the next request compute while rows drain. Reset
// is asynchronous and clears control only.
module look_at_view_matrix_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic signed [lav_pkg::DATA_W-1:0] eye_x,
    input  logic signed [lav_pkg::DATA_W-1:0] eye_y,
    input  logic signed [lav_pkg::DATA_W-1:0] eye_z,
    input  logic signed [lav_pkg::DATA_W-1:0] target_x,
    input  logic signed [lav_pkg::DATA_W-1:0] target_y,
    input  logic signed [lav_pkg::DATA_W-1:0] target_z,
    input  logic signed [lav_pkg::DATA_W-1:0] up_x,
    input  logic signed [lav_pkg::DATA_W-1:0] up_y,
    input  logic signed [lav_pkg::DATA_W-1:0] up_z,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [1:0]                        row_index,
    output logic signed [lav_pkg::DATA_W-1:0] col0,
    output logic signed [lav_pkg::DATA_W-1:0] col1,
    output logic signed [lav_pkg::DATA_W-1:0] col2,
    output logic signed [lav_pkg::DATA_W-1:0] col3,
    output logic                              degenerate,
    output logic                              last_row
);
    import lav_pkg::*;

    logic                     push_valid, push_ready;
    lav_item_t                push_item;
    logic                     q_valid, q_ready;
    lav_item_t                q_item;
    logic                     nrm_start;
    logic signed [CR_W-1:0]   nrm_vec [3];
    lav_nstat_t               nrm_stat;
    logic signed [UNIT_W-1:0] nrm_unit [3];

    lav_front u_front (
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .eye_x      (eye_x),
        .eye_y      (eye_y),
        .eye_z      (eye_z),
        .target_x   (target_x),
        .target_y   (target_y),
        .target_z   (target_z),
        .up_x       (up_x),
        .up_y       (up_y),
        .up_z       (up_z),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    lav_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_item   (q_item)
    );

    lav_norm u_norm (
        .clk   (clk),
        .rst_n (rst_n),
        .start (nrm_start),
        .vec   (nrm_vec),
        .stat  (nrm_stat),
        .unit  (nrm_unit)
    );

    lav_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_ready    (q_ready),
        .q_item     (q_item),
        .nrm_start  (nrm_start),
        .nrm_vec    (nrm_vec),
        .nrm_stat   (nrm_stat),
        .nrm_unit   (nrm_unit),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .row_index  (row_index),
        .col0       (col0),
        .col1       (col1),
        .col2       (col2),
        .col3       (col3),
        .degenerate (degenerate),
        .last_row   (last_row)
    );

    // rows of one request come out in order without a gap in the bank
    a_row_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && !last_row) |=>
            (out_valid && row_index == $past(row_index) + 2'd1))
        else $error("row sequence broken");

    a_deg_steady: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && !last_row) |=> (degenerate == $past(degenerate)))
        else $error("degenerate flag changed within a matrix");

    a_col3: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (col3 == (last_row ? ONE_Q : '0)))
        else $error("col3 does not match row");

endmodule

// ===== verif/tb_look_at_view_matrix_unit.sv =====
`timescale 1ns / 1ps
// Self-checking bench for look_at_view_matrix_unit: directed camera setups, then random ones,
// each checked row by row against a behavioral view-matrix predictor. Depends on lav_pkg.
module tb_look_at_view_matrix_unit;
    import lav_pkg::*;

    localparam int N_RANDOM    = 390;
    localparam int IDLE_LIMIT  = 20000;
    localparam int LONG_HOLD   = 1500;

    typedef struct {
        logic signed [31:0] v[9];
    } cam_req_t;

    typedef struct {
        logic [1:0]         row;
        logic signed [31:0] c0, c1, c2, c3;
        logic               degen;
        logic               last;
    } mat_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic signed [31:0] eye_x = '0, eye_y = '0, eye_z = '0;
    logic signed [31:0] target_x = '0, target_y = '0, target_z = '0;
    logic signed [31:0] up_x = '0, up_y = '0, up_z = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [1:0] row_index;
    logic signed [31:0] col0, col1, col2, col3;
    logic degenerate, last_row;

    mat_row_t expected_rows[$];
    int       mismatches = 0;
    int       idle_cycles = 0;
    bit       stim_done = 1'b0;
    bit       hold_out = 1'b0;
    int       sent = 0;

    look_at_view_matrix_unit u_dut (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .eye_x(eye_x), .eye_y(eye_y), .eye_z(eye_z),
        .target_x(target_x), .target_y(target_y), .target_z(target_z),
        .up_x(up_x), .up_y(up_y), .up_z(up_z),
        .out_valid(out_valid), .out_ready(out_ready), .row_index(row_index),
        .col0(col0), .col1(col1), .col2(col2), .col3(col3),
        .degenerate(degenerate), .last_row(last_row)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic longint unsigned int_sqrt(longint unsigned x);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > x) bitv >>= 2;
        while (bitv != 0)
        begin
            if (x >= res + bitv)
            begin
                x -= res + bitv;
                res = (res >> 1) + bitv;
            end
            else
                res >>= 1;
            bitv >>= 2;
        end
        return res;
    endfunction

    // Scale so the largest magnitude sits in [2^29, 2^30), then divide by the length.
    function automatic bit unit_vector(input longint c[3], output longint u[3]);
        longint unsigned mg[3], m, sum, len;
        m = 0;
        sum = 0;
        for (int i = 0; i < 3; i++)
        begin
            mg[i] = c[i] < 0 ? -c[i] : c[i];
            if (mg[i] > m) m = mg[i];
        end
        if (m == 0)
        begin
            u = '{0, 0, 0};
            return 1'b0;
        end
        while (m >= (64'd1 << 30))
        begin
            m >>= 1;
            for (int i = 0; i < 3; i++) mg[i] >>= 1;
        end
        while (m < (64'd1 << 29))
        begin
            m <<= 1;
            for (int i = 0; i < 3; i++) mg[i] <<= 1;
        end
        for (int i = 0; i < 3; i++) sum += mg[i] * mg[i];
        len = int_sqrt(sum);
        for (int i = 0; i < 3; i++)
        begin
            longint q;
            q = longint'((mg[i] << FRAC_BITS) / len);
            u[i] = c[i] < 0 ? -q : q;
        end
        return 1'b1;
    endfunction

    // Half-LSB round, then floor shift (arithmetic shift is floor on two's complement).
    function automatic longint round_q(longint v);
        return (v + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    endfunction

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    task automatic predict_view_rows(input cam_req_t rq);
        longint eye[3], d[3], f[3], cr[3], s[3], u[3], t[3];
        bit ok_f, ok_s;
        mat_row_t r;
        for (int i = 0; i < 3; i++)
        begin
            eye[i] = rq.v[i];
            d[i] = longint'(rq.v[3 + i]) - eye[i];
        end
        ok_f = unit_vector(d, f);
        cr[0] = f[1] * rq.v[8] - f[2] * rq.v[7];
        cr[1] = f[2] * rq.v[6] - f[0] * rq.v[8];
        cr[2] = f[0] * rq.v[7] - f[1] * rq.v[6];
        ok_s = unit_vector(cr, s);
        u[0] = round_q(s[1] * f[2] - s[2] * f[1]);
        u[1] = round_q(s[2] * f[0] - s[0] * f[2]);
        u[2] = round_q(s[0] * f[1] - s[1] * f[0]);
        t[0] = clamp32(-round_q(s[0] * eye[0] + s[1] * eye[1] + s[2] * eye[2]));
        t[1] = clamp32(-round_q(u[0] * eye[0] + u[1] * eye[1] + u[2] * eye[2]));
        t[2] = clamp32(round_q(f[0] * eye[0] + f[1] * eye[1] + f[2] * eye[2]));
        for (int k = 0; k < 4; k++)
        begin
            r.row = k[1:0];
            r.degen = !(ok_f && ok_s);
            r.last = (k == 3);
            if (k < 3)
            begin
                r.c0 = s[k][31:0];
                r.c1 = u[k][31:0];
                r.c2 = -f[k][31:0];
                r.c3 = '0;
            end
            else
            begin
                r.c0 = t[0][31:0];
                r.c1 = t[1][31:0];
                r.c2 = t[2][31:0];
                r.c3 = ONE_Q;
            end
            expected_rows.push_back(r);
        end
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got, exp_v);
        mismatches++;
        $display("mismatch %s: got %h expected %h", what, got, exp_v);
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
            2: return 32'(int'($urandom_range(0, 400)) - 200) <<< 16;
            default: return 32'(int'($urandom_range(0, 2000000)) - 1000000) <<< 4;
        endcase
    endfunction

    // Called at a falling edge; hold valid across requests when no gap is drawn.
    task automatic send_request(input cam_req_t rq);
        int gap;
        gap = $urandom_range(0, 6);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        {eye_x, eye_y, eye_z} = {rq.v[0], rq.v[1], rq.v[2]};
        {target_x, target_y, target_z} = {rq.v[3], rq.v[4], rq.v[5]};
        {up_x, up_y, up_z} = {rq.v[6], rq.v[7], rq.v[8]};
        in_valid <= 1'b1;
        do @(posedge clk); while (!in_ready);
        predict_view_rows(rq);
        sent++;
        @(negedge clk);
    endtask

    // Directed setups: eye, target, up.
    localparam int N_DIR = 14;
    logic signed [31:0] dir_tab[N_DIR][9] = '{
        '{0, 0, 0, 0, 0, 32'hffff0000, 0, 32'h10000, 0},
        '{0, 0, 32'h50000, 0, 0, 0, 0, 32'h10000, 0},
        '{32'h10000, 32'h20000, 32'h30000, 32'h10000, 32'h20000, 32'h30000, 0, 32'h10000, 0},
        '{0, 0, 0, 32'h10000, 0, 0, 32'h20000, 0, 0},
        '{0, 0, 0, 0, 32'h10000, 0, 0, 0, 0},
        '{32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000,
          32'h80000000, 0, 32'h10000, 0},
        '{32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff,
          32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h7fffffff},
        '{32'h80000000, 32'h7fffffff, 0, 32'h7fffffff, 32'h80000000, 1, 1, 1, 32'hffffffff},
        '{0, 0, 0, 1, 0, 0, 0, 1, 0},
        '{32'h7fffffff, 0, 32'h80000000, 0, 32'h7fffffff, 0, 32'h80000000, 0, 32'h80000000},
        '{32'h12345678, 32'h87654321, 32'h0badf00d, 32'hffffffff, 32'h55555555,
          32'haaaaaaaa, 32'h7fffffff, 32'h80000000, 0},
        '{0, 0, 32'h7fffffff, 0, 0, 32'h80000000, 0, 0, 32'h10000},
        '{32'hffffffff, 32'hffffffff, 32'hffffffff, 0, 0, 0, 32'h80000000, 32'h80000000,
          32'h80000000},
        '{32'h00010000, 0, 0, 32'h00010000, 32'h00030000, 32'hfffc0000, 0, 0, 32'h10000}
    };

    initial
    begin
        cam_req_t rq;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        for (int n = 0; n < N_DIR; n++)
        begin
            for (int i = 0; i < 9; i++) rq.v[i] = dir_tab[n][i];
            send_request(rq);
        end
        for (int n = 0; n < N_RANDOM; n++)
        begin
            for (int i = 0; i < 9; i++) rq.v[i] = rand_coord();
            case ($urandom_range(0, 9))
                0: for (int i = 0; i < 3; i++) rq.v[3 + i] = rq.v[i];
                1: for (int i = 0; i < 3; i++) rq.v[6 + i] = '0;
                2: for (int i = 0; i < 3; i++) rq.v[6 + i] = rq.v[3 + i] - rq.v[i];
                default: ;
            endcase
            if (n == 60) hold_out = 1'b1;
            send_request(rq);
        end
        in_valid <= 1'b0;
        stim_done = 1'b1;
    end

    // Receiver: random stalls, plus one long hold-off while requests keep coming.
    initial
    begin
        int gap;
        forever
        begin
            @(negedge clk);
            if (hold_out)
            begin
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
                hold_out = 1'b0;
            end
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6);
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!(out_valid && out_ready));
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            mat_row_t e;
            if (expected_rows.size() == 0)
                report_mismatch("unexpected row", {30'b0, row_index}, '0);
            else
            begin
                e = expected_rows.pop_front();
                if (row_index !== e.row) report_mismatch("row_index", row_index, e.row);
                if (col0 !== e.c0) report_mismatch("col0", col0, e.c0);
                if (col1 !== e.c1) report_mismatch("col1", col1, e.c1);
                if (col2 !== e.c2) report_mismatch("col2", col2, e.c2);
                if (col3 !== e.c3) report_mismatch("col3", col3, e.c3);
                if (degenerate !== e.degen)
                    report_mismatch("degenerate", degenerate, e.degen);
                if (last_row !== e.last) report_mismatch("last_row", last_row, e.last);
            end
        end
    end

    // Watchdog and end of run.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || hold_out)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        wait (stim_done && expected_rows.size() == 0);
        repeat (300) @(posedge clk);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
